// ===== rtl/core/lzw_compressor_top_defines.svh =====
// ---------------------------------------------------------------------------
// lzw_compressor_top_defines.svh
// Assertion macros used by the LZW compressor top.
// ---------------------------------------------------------------------------
`ifndef LZW_COMPRESSOR_TOP_DEFINES_SVH
`define LZW_COMPRESSOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LZW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define LZW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/lzwc_pkg.sv =====
// ---------------------------------------------------------------------------
// lzwc_pkg
// Types and constants shared by the LZW compressor controller and datapath.
// ---------------------------------------------------------------------------
package lzwc_pkg;

    localparam int unsigned LZWC_MAX_CODES = 4096;

    // Configuration register indexes (paddr[2])
    localparam logic REG_MIN_CODE_LEN = 1'b0;
    localparam logic REG_TABLE_SIZE   = 1'b1;

    localparam logic [3:0]  MIN_LEN_RESET  = 4'd9;
    localparam logic [12:0] TBL_SIZE_RESET = 13'd4096;
    localparam logic [3:0]  MIN_LEN_LO     = 4'd3;
    localparam logic [3:0]  MIN_LEN_HI     = 4'd9;
    localparam logic [12:0] TBL_SIZE_LO    = 13'd16;
    localparam logic [3:0]  WIDTH_TOP      = 4'd12;

    typedef enum logic [1:0] {
        EMIT_PREFIX,
        EMIT_CLEAR,
        EMIT_END
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      init_dict;
        logic      set_prefix_ch;
        logic      set_prefix_node;
        logic      clr_prefix;
        logic      set_stream;
        logic      clr_stream;
        logic      step_fc;
        logic      step_ns;
        logic      mark_tail;
        logic      add_entry;
        logic      link_entry;
        logic      grow_width;
        logic      emit;
        emit_sel_t emit_sel;
    } lzw_cmd_t;

    typedef struct packed {
        logic fc_zero;
        logic ns_zero;
        logic char_hit;
        logic table_full;
        logic in_stream;
        logic last;
        logic out_free;
    } lzw_sts_t;

endpackage

// ===== rtl/core/lzwc_in_if.sv =====
// ---------------------------------------------------------------------------
// lzwc_in_if
// Source byte channel: valid/ready handshake with byte and last marker.
// ---------------------------------------------------------------------------
interface lzwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/lzwc_out_if.sv =====
// ---------------------------------------------------------------------------
// lzwc_out_if
// Code channel: valid/ready handshake with code, width and end marker.
// ---------------------------------------------------------------------------
interface lzwc_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] code;
    logic [3:0]  code_width;
    logic        end_of_stream;

    modport source (output valid, output code, output code_width, output end_of_stream,
                    input ready);
    modport sink   (input valid, input code, input code_width, input end_of_stream,
                    output ready);
endinterface

// ===== rtl/core/lzwc_ctrl.sv =====
// ---------------------------------------------------------------------------
// lzwc_ctrl
// Sequencer for the LZW compressor: search, emit, add and flush steps.
// ---------------------------------------------------------------------------
module lzwc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lzwc_pkg::lzw_sts_t sts,
    output lzwc_pkg::lzw_cmd_t cmd
);
    import lzwc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_EM_START,
        ST_RD_FC,
        ST_CHK,
        ST_CMP,
        ST_EM_PFX,
        ST_EM_CLR,
        ST_ADD1,
        ST_ADD2,
        ST_GROW,
        ST_EM_LASTP,
        ST_EM_END
    } state_t;

    state_t state_reg, state_next;
    state_t done_state;

    // After the byte is handled, flush on last byte or go idle
    assign done_state = sts.last ? ST_EM_LASTP : ST_IDLE;
    assign in_ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.emit_sel = EMIT_PREFIX;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_stream ? ST_RD_FC : ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init_dict = 1'b1;
                state_next    = ST_EM_START;
            end
            ST_EM_START:
            begin
                if (sts.out_free)
                begin
                    cmd.emit          = 1'b1;
                    cmd.emit_sel      = EMIT_CLEAR;
                    cmd.set_prefix_ch = 1'b1;
                    cmd.set_stream    = 1'b1;
                    state_next        = done_state;
                end
            end
            ST_RD_FC:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.fc_zero)
                begin
                    state_next = ST_EM_PFX;
                end
                else
                begin
                    cmd.step_fc = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (sts.char_hit)
                begin
                    cmd.set_prefix_node = 1'b1;
                    state_next          = done_state;
                end
                else if (sts.ns_zero)
                begin
                    cmd.mark_tail = 1'b1;
                    state_next    = ST_EM_PFX;
                end
                else
                begin
                    cmd.step_ns = 1'b1;
                end
            end
            ST_EM_PFX:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.table_full ? ST_EM_CLR : ST_ADD1;
                end
            end
            ST_EM_CLR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_CLEAR;
                    cmd.init_dict = 1'b1;
                    state_next    = ST_GROW;
                end
            end
            ST_ADD1:
            begin
                cmd.add_entry = 1'b1;
                state_next    = ST_ADD2;
            end
            ST_ADD2:
            begin
                cmd.link_entry = 1'b1;
                state_next     = ST_GROW;
            end
            ST_GROW:
            begin
                cmd.grow_width    = 1'b1;
                cmd.set_prefix_ch = 1'b1;
                state_next        = done_state;
            end
            ST_EM_LASTP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_EM_END;
                end
            end
            ST_EM_END:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = EMIT_END;
                    cmd.clr_prefix = 1'b1;
                    cmd.clr_stream = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/lzwc_dp.sv =====
// ---------------------------------------------------------------------------
// lzwc_dp
// LZW datapath: config registers, dictionary memories, prefix and width
// state, and the output register.
// ---------------------------------------------------------------------------
module lzwc_dp #(
    parameter int unsigned MAX_CODES = lzwc_pkg::LZWC_MAX_CODES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lzwc_pkg::lzw_cmd_t cmd,
    output lzwc_pkg::lzw_sts_t sts,
    input  logic [7:0]         in_data_byte,
    input  logic               in_last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [11:0]        out_code,
    output logic [3:0]         out_code_width,
    output logic               out_end_of_stream,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lzwc_pkg::*;

    localparam int unsigned TBL_MAX   = (MAX_CODES < 4096) ? MAX_CODES : 4096;
    localparam int unsigned MEM_DEPTH = (TBL_MAX > 256) ? TBL_MAX : 256;
    localparam int unsigned AW        = $clog2(MEM_DEPTH);
    localparam logic [12:0] TBL_MAX_C = 13'(TBL_MAX);

    // Configuration
    logic [3:0]  min_len_reg;
    logic [12:0] tbl_size_reg;
    logic [3:0]  emin;
    logic [12:0] etbl;
    logic [8:0]  alpha;

    // Item and search state
    logic [7:0]  ch_reg;
    logic        last_reg;
    logic [11:0] prefix_reg, prefix_next;
    logic [11:0] node_reg, node_next;
    logic [11:0] tail_reg;
    logic        tail_vld_reg;
    logic [12:0] next_free_reg, next_free_next;
    logic [3:0]  width_reg, width_next;
    logic        in_stream_reg;
    logic [255:0] root_vld_reg;

    // Output register
    logic        out_valid_reg;
    logic [11:0] out_code_reg;
    logic [3:0]  out_width_reg;
    logic        out_eos_reg;

    // Memories
    logic [11:0] fc_mem [MEM_DEPTH];
    logic [11:0] ns_mem [MEM_DEPTH];
    logic [7:0]  ec_mem [MEM_DEPTH];
    logic [11:0] fc_q, ns_q;
    logic [7:0]  ec_q;
    logic [11:0] fc_link;
    logic        prefix_is_root;
    logic        fc_we, ns_we;
    logic [AW-1:0] fc_waddr, ns_waddr;
    logic [11:0] fc_wdata, ns_wdata;
    logic [AW-1:0] n_addr;
    logic        grow_ok;
    logic        out_free;

    assign pready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg  <= MIN_LEN_RESET;
            tbl_size_reg <= TBL_SIZE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_MIN_CODE_LEN: min_len_reg  <= pwdata[3:0];
                REG_TABLE_SIZE:   tbl_size_reg <= pwdata[12:0];
                default:          min_len_reg  <= min_len_reg;
            endcase
        end
    end

    // Read back configuration
    always_comb
    begin
        case (paddr[2])
            REG_MIN_CODE_LEN: prdata = {28'd0, min_len_reg};
            REG_TABLE_SIZE:   prdata = {19'd0, tbl_size_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Saturate configuration
    assign emin  = (min_len_reg < MIN_LEN_LO) ? MIN_LEN_LO :
                   (min_len_reg > MIN_LEN_HI) ? MIN_LEN_HI : min_len_reg;
    assign etbl  = (tbl_size_reg < TBL_SIZE_LO) ? TBL_SIZE_LO :
                   (tbl_size_reg > TBL_MAX_C) ? TBL_MAX_C : tbl_size_reg;
    assign alpha = 9'd1 << (emin - 4'd1);

    // Root entries keep their child link behind a valid bit
    assign prefix_is_root = (prefix_reg < {3'd0, alpha});
    assign fc_link = (prefix_is_root && !root_vld_reg[prefix_reg[7:0]]) ? 12'd0 : fc_q;

    // Follow the chain
    always_comb
    begin
        node_next = node_reg;
        if (cmd.step_fc)
        begin
            node_next = fc_link;
        end
        else if (cmd.step_ns)
        begin
            node_next = ns_q;
        end
    end

    assign n_addr = next_free_reg[AW-1:0];

    // Memory write ports
    always_comb
    begin
        fc_we    = 1'b0;
        fc_waddr = n_addr;
        fc_wdata = 12'd0;
        ns_we    = 1'b0;
        ns_waddr = n_addr;
        ns_wdata = 12'd0;
        if (cmd.add_entry)
        begin
            fc_we = 1'b1;
            ns_we = 1'b1;
        end
        else if (cmd.link_entry)
        begin
            if (tail_vld_reg)
            begin
                ns_we    = 1'b1;
                ns_waddr = tail_reg[AW-1:0];
                ns_wdata = next_free_reg[11:0];
            end
            else
            begin
                fc_we    = 1'b1;
                fc_waddr = prefix_reg[AW-1:0];
                fc_wdata = next_free_reg[11:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fc_we)
        begin
            fc_mem[fc_waddr] <= fc_wdata;
        end
        fc_q <= fc_mem[prefix_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ns_we)
        begin
            ns_mem[ns_waddr] <= ns_wdata;
        end
        ns_q <= ns_mem[node_next[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_entry)
        begin
            ec_mem[n_addr] <= ch_reg;
        end
        ec_q <= ec_mem[node_next[AW-1:0]];
    end

    // Width grows, up to 12 bits, when the next free code passes the current range and is below the table size
    assign grow_ok = (width_reg < WIDTH_TOP)
                  && (next_free_reg == ((13'd1 << width_reg) + 13'd1))
                  && (next_free_reg < etbl);

    always_comb
    begin
        prefix_next    = prefix_reg;
        next_free_next = next_free_reg;
        width_next     = width_reg;
        if (cmd.set_prefix_ch)
        begin
            prefix_next = {4'd0, ch_reg};
        end
        else if (cmd.set_prefix_node)
        begin
            prefix_next = node_reg;
        end
        else if (cmd.clr_prefix)
        begin
            prefix_next = 12'd0;
        end
        if (cmd.init_dict)
        begin
            next_free_next = {4'd0, alpha} + 13'd2;
            width_next     = emin;
        end
        else if (cmd.link_entry)
        begin
            next_free_next = next_free_reg + 13'd1;
        end
        else if (cmd.grow_width && grow_ok)
        begin
            width_next = width_reg + 4'd1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= 12'd0;
            next_free_reg <= 13'd258;
            width_reg     <= MIN_LEN_RESET;
            in_stream_reg <= 1'b0;
            root_vld_reg  <= '0;
            tail_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prefix_reg    <= prefix_next;
            next_free_reg <= next_free_next;
            width_reg     <= width_next;
            if (cmd.set_stream)
            begin
                in_stream_reg <= 1'b1;
            end
            else if (cmd.clr_stream)
            begin
                in_stream_reg <= 1'b0;
            end
            if (cmd.init_dict)
            begin
                root_vld_reg <= '0;
            end
            else if (cmd.link_entry && !tail_vld_reg && prefix_is_root)
            begin
                root_vld_reg[prefix_reg[7:0]] <= 1'b1;
            end
            if (cmd.load)
            begin
                tail_vld_reg <= 1'b0;
            end
            else if (cmd.mark_tail || cmd.step_ns)
            begin
                tail_vld_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        if (cmd.load)
        begin
            ch_reg   <= in_data_byte & alpha[7:0] - 8'd1;
            last_reg <= in_last_byte;
        end
        if (cmd.mark_tail || cmd.step_ns)
        begin
            tail_reg <= node_reg;
        end
        if (cmd.emit)
        begin
            out_width_reg <= width_reg;
            out_eos_reg   <= (cmd.emit_sel == EMIT_END);
            case (cmd.emit_sel)
                EMIT_PREFIX: out_code_reg <= prefix_reg;
                EMIT_CLEAR:  out_code_reg <= {3'd0, alpha};
                EMIT_END:    out_code_reg <= {3'd0, alpha} + 12'd1;
                default:     out_code_reg <= prefix_reg;
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    assign sts.fc_zero    = (fc_link == 12'd0);
    assign sts.ns_zero    = (ns_q == 12'd0);
    assign sts.char_hit   = (ec_q == ch_reg);
    assign sts.table_full = (next_free_reg >= etbl);
    assign sts.in_stream  = in_stream_reg;
    assign sts.last       = last_reg;
    assign sts.out_free   = out_free;

    assign out_valid         = out_valid_reg;
    assign out_code          = out_code_reg;
    assign out_code_width    = out_width_reg;
    assign out_end_of_stream = out_eos_reg;

endmodule

// ===== rtl/core/lzw_compressor_top.sv =====
// ---------------------------------------------------------------------------
// lzw_compressor_top
// Variable-width LZW compressor with clear and end codes.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch takes one source byte per transfer; last_byte closes the stream.
//   out_ch gives codes with their packed width; end_of_stream marks the
//   end code. A stream opens with a clear code.
//   Config (APB): min_code_len at 0x0, table_size at 0x4; write only while
//   idle. Reads return the stored value.
// Sequence:
//   One byte at a time. First byte of a stream: dictionary init, then the
//   clear code emit. Dictionary hit: read, check and compare steps, with one
//   compare per sibling link visited, as the child/sibling memories have a
//   single read port. Miss: the hit steps, then emit, add and grow (a clear
//   code when the table is full). Last byte adds prefix and end code emits.
// Reset: config returns to 9 and 4096; the next byte starts a new stream.
// Stall: a one-deep output register holds the code; the sequencer waits at
//   each emit until the receiver takes the previous code.
// ---------------------------------------------------------------------------
`include "lzw_compressor_top_defines.svh"

module lzw_compressor_top #(
    parameter int unsigned MAX_CODES = lzwc_pkg::LZWC_MAX_CODES
) (
    input  logic        clk,
    input  logic        rst_n,
    lzwc_in_if.sink     in_ch,
    lzwc_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lzwc_pkg::*;

    lzw_cmd_t cmd;
    lzw_sts_t sts;

    // Sequencer
    lzwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    lzwc_dp #(
        .MAX_CODES (MAX_CODES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .in_data_byte      (in_ch.data_byte),
        .in_last_byte      (in_ch.last_byte),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .out_code          (out_ch.code),
        .out_code_width    (out_ch.code_width),
        .out_end_of_stream (out_ch.end_of_stream),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Checks
    `LZW_ASSERT_NOW(a_no_overrun, clk, rst_n, cmd.emit, sts.out_free)
    `LZW_ASSERT_NOW(a_add_has_room, clk, rst_n, cmd.link_entry, !sts.table_full)
    `LZW_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule
